// File: sv/arp_pkg.sv
// Package for the response line parser: character classes, queue item type, nibble table.
package arp_pkg;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes that steer the port reader.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    // Index folding for the nibble table.
    localparam logic [4:0] NIB_INDEX_FLIP = 5'h10;

    // Largest port value; the decimal reader saturates here.
    localparam logic [11:0] PORT_MAX = 12'd255;
    localparam logic [11:0] DEC_BASE = 12'd10;

    // Case-insensitive hex nibble table, indexed by (ch & 0x1F) ^ 0x10.
    localparam logic [3:0] NIBBLE_TABLE [32] = '{
        4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
        4'h8, 4'h9, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
        4'h0, 4'ha, 4'hb, 4'hc, 4'hd, 4'he, 4'hf, 4'h0,
        4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0
    };

    // Class of one received character.
    typedef enum logic [2:0] {
        CL_OTHER,
        CL_COLON,
        CL_COMMA,
        CL_SPACE,
        CL_DIGIT
    } ch_class_t;

    // Phase of the decimal port reader.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } digit_phase_t;

    // Classified item as it travels through the queue.
    typedef struct packed {
        ch_class_t  cls;
        logic [3:0] nibble;
        logic       eom;
    } arp_item_t;

endpackage

// File: sv/arp_front.sv
// Front part: classifies each received character and looks up its hex nibble.
module arp_front (
    input  logic              [7:0] ch,
    input  logic                    end_of_message,
    output arp_pkg::arp_item_t      item
);
    import arp_pkg::*;

    logic is_digit;
    logic is_hex;

    // Hex and digit detection.
    always_comb
    begin
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        is_hex   = is_digit || ((ch >= CHAR_UP_A) && (ch <= CHAR_UP_F)) ||
                   ((ch >= CHAR_LO_A) && (ch <= CHAR_LO_F));
    end

    // Character class, nibble value and end flag.
    always_comb
    begin
        if (ch == CHAR_COLON)
        begin
            item.cls = CL_COLON;
        end
        else if (ch == CHAR_COMMA)
        begin
            item.cls = CL_COMMA;
        end
        else if (ch == CHAR_SPACE)
        begin
            item.cls = CL_SPACE;
        end
        else if (is_digit)
        begin
            item.cls = CL_DIGIT;
        end
        else
        begin
            item.cls = CL_OTHER;
        end
        item.nibble = is_hex ? NIBBLE_TABLE[ch[4:0] ^ NIB_INDEX_FLIP] : 4'h0;
        item.eom    = end_of_message;
    end

endmodule

// File: sv/arp_queue.sv
// Short register queue between the front and back parts.
module arp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  arp_pkg::arp_item_t      push_item,
    input  logic                    pop,
    output arp_pkg::arp_item_t      head_item,
    output logic                    not_empty,
    output logic                    full
);
    import arp_pkg::*;

    arp_item_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    // Status toward both sides.
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/arp_back.sv
// Back part: port reader, hex byte assembly and the registered result stage.
module arp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  arp_pkg::arp_item_t      item,
    input  logic                    item_valid,
    output logic                    item_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic              [7:0] data_byte,
    output logic              [7:0] port_number,
    output logic                    has_data,
    output logic                    colon_found,
    output logic                    last
);
    import arp_pkg::*;

    logic         in_payload_reg;
    logic         in_payload_next;
    logic [7:0]   port_accum_reg;
    logic [7:0]   port_accum_next;
    digit_phase_t phase_reg;
    digit_phase_t phase_next;
    logic [7:0]   port_latched_reg;
    logic [7:0]   port_latched_next;
    logic [3:0]   high_nibble_reg;
    logic [3:0]   high_nibble_next;
    logic         pending_reg;
    logic         pending_next;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   data_byte_reg;
    logic [7:0]   port_number_reg;
    logic         has_data_reg;
    logic         colon_found_reg;
    logic         last_reg;

    logic         have_byte;
    logic         make_result;
    logic [11:0]  port_sum;
    logic [7:0]   res_data;
    logic [7:0]   res_port;

    // The next item is taken whenever the result stage is free or draining.
    assign item_pop    = item_valid && (!out_valid_reg || !out_stall);
    assign make_result = item_pop && (have_byte || item.eom);

    // Saturating decimal accumulate.
    assign port_sum = ({4'b0, port_accum_reg} * DEC_BASE) + {8'b0, item.nibble};

    // Next state of the parser for the item at the queue head.
    always_comb
    begin
        in_payload_next   = in_payload_reg;
        port_accum_next   = port_accum_reg;
        phase_next        = phase_reg;
        port_latched_next = port_latched_reg;
        high_nibble_next  = high_nibble_reg;
        pending_next      = pending_reg;
        if (!in_payload_reg)
        begin
            unique case (item.cls)
                CL_COLON:
                begin
                    in_payload_next   = 1'b1;
                    port_latched_next = port_accum_reg;
                end
                CL_COMMA:
                begin
                    port_accum_next = '0;
                    phase_next      = PH_SKIP;
                end
                CL_SPACE:
                begin
                    if (phase_reg != PH_SKIP)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                CL_DIGIT:
                begin
                    if (phase_reg != PH_DONE)
                    begin
                        port_accum_next = (port_sum > PORT_MAX) ?
                                          PORT_MAX[7:0] : port_sum[7:0];
                        phase_next      = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
        else if (!pending_reg)
        begin
            high_nibble_next = item.nibble;
            pending_next     = 1'b1;
        end
        else
        begin
            pending_next = 1'b0;
        end

        // The end of a line returns everything to the reset values.
        if (item.eom)
        begin
            in_payload_next   = 1'b0;
            port_accum_next   = '0;
            phase_next        = PH_SKIP;
            port_latched_next = '0;
            high_nibble_next  = '0;
            pending_next      = 1'b0;
        end
    end

    // Result fields for the item at the queue head.
    always_comb
    begin
        have_byte = in_payload_reg && pending_reg;
        res_data  = have_byte ? {high_nibble_reg, item.nibble} : 8'h00;
        if (in_payload_reg)
        begin
            res_port = port_latched_reg;
        end
        else if (item.cls == CL_COLON)
        begin
            res_port = port_accum_reg;
        end
        else
        begin
            res_port = 8'h00;
        end
    end

    // Result stage valid flag.
    always_comb
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = make_result;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Parser and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            port_accum_reg   <= '0;
            phase_reg        <= PH_SKIP;
            port_latched_reg <= '0;
            high_nibble_reg  <= '0;
            pending_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                in_payload_reg   <= in_payload_next;
                port_accum_reg   <= port_accum_next;
                phase_reg        <= phase_next;
                port_latched_reg <= port_latched_next;
                high_nibble_reg  <= high_nibble_next;
                pending_reg      <= pending_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (make_result)
        begin
            data_byte_reg   <= res_data;
            port_number_reg <= res_port;
            has_data_reg    <= have_byte;
            colon_found_reg <= in_payload_reg || (item.cls == CL_COLON);
            last_reg        <= item.eom;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = data_byte_reg;
    assign port_number = port_number_reg;
    assign has_data    = has_data_reg;
    assign colon_found = colon_found_reg;
    assign last        = last_reg;

endmodule

// File: sv/at_recv_response_parser.sv
// Top level of the received response line parser: front, queue and back part.
//
//  channel  | handshake          | fields
//  ---------+--------------------+-----------------------------------------------------
//  input    | in_valid/in_stall  | ch, end_of_message
//  output   | out_valid/out_stall| data_byte, port_number, has_data, colon_found, last
//
// One character is accepted per cycle while in_stall is low. Its result, if any, is loaded
// into the output register at the edge where it leaves the two-entry queue, so a character
// is held first in a queue slot and its result then in the output register.
// Reset clears the parser state, the queue pointers and the result valid flag; no clearing pass.
// An output stall fills the queue; in_stall rises only when both queue slots hold items.
module at_recv_response_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic [7:0] port_number,
    output logic       has_data,
    output logic       colon_found,
    output logic       last
);
    import arp_pkg::*;

    arp_item_t front_item;
    arp_item_t head_item;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_push;
    logic      queue_pop;

    // An item enters the queue whenever a slot is free.
    assign in_stall   = queue_full;
    assign queue_push = in_valid && !queue_full;

    arp_front u_front (
        .ch             (ch),
        .end_of_message (end_of_message),
        .item           (front_item)
    );

    arp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_item (front_item),
        .pop       (queue_pop),
        .head_item (head_item),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    arp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (head_item),
        .item_valid  (queue_not_empty),
        .item_pop    (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .port_number (port_number),
        .has_data    (has_data),
        .colon_found (colon_found),
        .last        (last)
    );

endmodule
